### rtl/float_to_int_trunc_trap_defines.svh
// Assertion macros used by the checker file of the float truncation block.
// Holds only macro definitions; no dependencies.
`ifndef FLOAT_TO_INT_TRUNC_TRAP_DEFINES_SVH
`define FLOAT_TO_INT_TRUNC_TRAP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define FTI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Non-overlapped implication: the consequent is checked in the cycle after the antecedent.
`define FTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication whose consequent is checked after a delay from the antecedent.
`define FTI_ASSERT_TWO(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

### rtl/fti_pkg.sv
// Package for the float truncation block: request codes and the result type.
// No dependencies.
package fti_pkg;

  typedef enum logic [2:0] {
    REQ_F32_U32 = 3'd0,
    REQ_F32_I32 = 3'd1,
    REQ_F64_U32 = 3'd2,
    REQ_F64_I32 = 3'd3,
    REQ_F32_U64 = 3'd4,
    REQ_F32_I64 = 3'd5,
    REQ_F64_U64 = 3'd6,
    REQ_F64_I64 = 3'd7
  } req_type_e;

  typedef struct packed {
    logic [63:0] result_bits;
    logic        trap;
  } conv_res_t;

endpackage

### rtl/fti_conv.sv
// Combinational float to integer truncation with range trap.
// Depends on fti_pkg.
module fti_conv (
  input  logic [2:0]         req_type_i,
  input  logic [63:0]        raw_bits_i,
  output fti_pkg::conv_res_t res_o
);

  logic        src64, is_signed, dst64, neg, special, big;
  logic [10:0] expf;
  logic [52:0] mant;
  logic [10:0] e;
  logic        ge_bias;
  logic [63:0] mag, lim, neg_mag;
  logic        trap;
  logic [63:0] res;

  // Field decode for the two source formats.
  always_comb begin
    src64     = req_type_i[1];
    is_signed = req_type_i[0];
    dst64     = req_type_i[2];
    if (src64) begin
      neg     = raw_bits_i[63];
      expf    = raw_bits_i[62:52];
      mant    = {1'b1, raw_bits_i[51:0]};
      special = (expf == 11'h7FF);
      ge_bias = (expf >= 11'd1023);
      e       = expf - 11'd1023;
    end else begin
      neg     = raw_bits_i[31];
      expf    = {3'b000, raw_bits_i[30:23]};
      mant    = {1'b1, raw_bits_i[22:0], 29'd0};
      special = (expf == 11'h0FF);
      ge_bias = (expf >= 11'd127);
      e       = expf - 11'd127;
    end
  end

  // Magnitude by one shift; a 53-bit aligned mantissa, point after the top bit.
  always_comb begin
    big = ge_bias && (e >= 11'd64);
    mag = '0;
    if (ge_bias && !big) begin
      if (e >= 11'd52) mag = {11'd0, mant} << (e[5:0] - 6'd52);
      else             mag = {11'd0, mant} >> (6'd52 - e[5:0]);
    end
  end

  // Range check and sign application.
  always_comb begin
    lim     = dst64 ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
    neg_mag = 64'd0 - mag;
    res     = mag;
    if (special || big) begin
      trap = 1'b1;
    end else if (!is_signed) begin
      if (neg) trap = (mag != 64'd0);
      else     trap = !dst64 && (mag[63:32] != 32'd0);
    end else if (neg) begin
      trap = (mag > lim);
      res  = neg_mag;
    end else begin
      trap = (mag >= lim);
    end
    if (trap)        res = '0;
    else if (!dst64) res = {32'd0, res[31:0]};
    res_o.result_bits = res;
    res_o.trap        = trap;
  end

endmodule

### rtl/float_to_int_trunc_trap.sv
// Top level of the float to integer truncation block with trap.
// Depends on fti_pkg and fti_conv.
//
// Channel  | Dir | tdata (low bit first)        | tuser
// s_axis   | in  | req_type[2:0], raw_bits[66:3] | -
// m_axis   | out | result_bits[63:0]             | trap
//
// One word is accepted per cycle while the skid register is empty. An accepted
// word passes the input register, fti_conv and the result register to the output.
// A held result blocks input only after a skid register has taken one extra word.
// Reset clears the valid flags only.
module float_to_int_trunc_trap (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // req_type[2:0], raw_bits[66:3], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // result_bits[63:0]
  output logic        m_axis_tuser    // trap
);

  logic               in_vld_q, out_vld_q, skid_vld_q;
  logic [2:0]         req_q;
  logic [63:0]        raw_q;
  fti_pkg::conv_res_t conv, out_q, skid_q;
  logic               s_acc, m_acc, adv;

  fti_conv u_conv (.req_type_i(req_q), .raw_bits_i(raw_q), .res_o(conv));

  // Stage moves when the result register is free or being drained.
  assign m_acc         = m_axis_tvalid && m_axis_tready;
  assign adv           = !out_vld_q || m_acc;
  assign s_axis_tready = !skid_vld_q;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q.result_bits;
  assign m_axis_tuser  = out_q.trap;

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        out_vld_q  <= in_vld_q || skid_vld_q;
        in_vld_q   <= s_acc || (skid_vld_q && in_vld_q);
        skid_vld_q <= 1'b0;
      end else if (in_vld_q && s_acc) begin
        skid_vld_q <= 1'b1;
      end else if (s_acc) begin
        in_vld_q <= 1'b1;
      end
    end
  end

  // Payload registers. The skid slot holds a converted result waiting for output.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (skid_vld_q) begin
        out_q  <= skid_q;
        if (!s_acc) begin
          req_q <= req_q;
          raw_q <= raw_q;
        end
      end else begin
        out_q <= conv;
      end
      if (s_acc) begin
        req_q <= s_axis_tdata[2:0];
        raw_q <= s_axis_tdata[66:3];
      end
    end else if (in_vld_q && s_acc) begin
      skid_q <= conv;
      req_q  <= s_axis_tdata[2:0];
      raw_q  <= s_axis_tdata[66:3];
    end else if (s_acc) begin
      req_q <= s_axis_tdata[2:0];
      raw_q <= s_axis_tdata[66:3];
    end
  end

endmodule

### rtl/fti_checker.sv
// Port-level checker for the float truncation block, bound to the top level.
// Depends on float_to_int_trunc_trap_defines.svh.
`include "float_to_int_trunc_trap_defines.svh"
module fti_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  // A trapped word always carries a zero result.
  `FTI_ASSERT_IMP(a_trap_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 64'd0, "trap with nonzero result")
  // A stalled result holds.
  `FTI_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  // An accepted word is followed by a valid result on the output port.
  `FTI_ASSERT_TWO(a_lat, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, m_axis_tvalid, "no result after accept")
  // Input is refused only while a result waits.
  `FTI_ASSERT_IMP(a_ready, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid, "input stalled with empty output")
endmodule

bind float_to_int_trunc_trap fti_checker u_fti_checker (.*);

### bench/tb_top.sv
// Testbench for float_to_int_trunc_trap: float-to-integer truncation with trap.
// Depends on fti_pkg and the block's RTL; a small scoreboard predicts each result.
`timescale 1ns / 100ps

class trunc_scoreboard;
  logic [63:0] want_bits_q[$];
  logic        want_trap_q[$];
  int          errors;

  // Predict the integer pattern and trap flag for one accepted word.
  function void note_input(fti_pkg::req_type_e kind, logic [63:0] raw);
    logic        from64, signed_dst, to64, neg, bad;
    logic [10:0] expo;
    int          unbiased, fbits;
    logic [63:0] mant, mag, limit, val;
    from64     = kind[1];
    signed_dst = kind[0];
    to64       = kind[2];
    bad        = 1'b0;
    mag        = '0;
    if (from64) begin
      neg = raw[63];
      expo = raw[62:52];
      mant = {12'h001, raw[51:0]};
      fbits = 52;
      unbiased = int'(expo) - 1023;
      bad = (expo == 11'h7ff);
    end else begin
      neg = raw[31];
      expo = {3'b000, raw[30:23]};
      mant = {40'h0, 1'b1, raw[22:0]};
      fbits = 23;
      unbiased = int'(expo) - 127;
      bad = (expo == 11'h0ff);
    end
    if (!bad && unbiased >= 0) begin
      if (unbiased >= 64) bad = 1'b1;
      else if (unbiased >= fbits) mag = mant << (unbiased - fbits);
      else mag = mant >> (fbits - unbiased);
    end
    val = mag;
    if (!bad) begin
      if (!signed_dst) begin
        bad = neg ? (mag != 0) : (!to64 && mag > 64'hffff_ffff);
      end else begin
        limit = to64 ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
        bad = neg ? (mag > limit) : (mag > limit - 1);
        if (neg) val = -mag;
      end
    end
    if (bad) val = '0;
    else if (!to64) val[63:32] = '0;
    want_bits_q.push_back(val);
    want_trap_q.push_back(bad);
  endfunction

  // Compare one result word with the oldest prediction.
  task check_result(logic [63:0] bits, logic trap);
    logic [63:0] wb;
    logic        wt;
    if (want_bits_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result %h trap %b", bits, trap));
      return;
    end
    wb = want_bits_q.pop_front();
    wt = want_trap_q.pop_front();
    if (bits !== wb) report_mismatch($sformatf("result_bits %h, want %h", bits, wb));
    if (trap !== wt) report_mismatch($sformatf("trap %b, want %b", trap, wt));
  endtask

  task report_mismatch(string msg);
    errors++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  function int pending();
    return want_bits_q.size();
  endfunction
endclass

module tb_top;

  localparam int NumRandom = 1500;
  localparam int StallLimit = 5000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;

  trunc_scoreboard sb;
  int  idle_cycles = 0;
  int  words_in, words_out, traps_seen;
  bit  drive_done;
  bit  timed_out;

  float_to_int_trunc_trap dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // req_type[2:0], raw_bits[66:3], zero pad
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // result_bits[63:0]
    .m_axis_tuser  (m_axis_tuser)    // trap
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Gap length: mostly zero or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Send one word and wait for its acceptance.
  task automatic send_word(fti_pkg::req_type_e kind, logic [63:0] raw);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, raw, kind};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(kind, raw);
    words_in++;
  endtask

  task automatic send_gap();
    int n;
    n = pick_gap();
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Random float near the interesting region of the chosen formats.
  function automatic logic [63:0] pick_raw(fti_pkg::req_type_e kind);
    logic [63:0] raw;
    int r;
    raw = {$urandom, $urandom};
    r = $urandom_range(0, 9);
    if (kind[1]) begin
      if (r < 7) raw[62:52] = 11'($urandom_range(1000, 1090));
      else if (r == 7) raw[62:52] = 11'h7ff;
      else if (r == 8) raw[62:52] = 11'h000;
    end else begin
      if (r < 7) raw[30:23] = 8'($urandom_range(110, 192));
      else if (r == 7) raw[30:23] = 8'hff;
      else if (r == 8) raw[30:23] = 8'h00;
    end
    if ($urandom_range(0, 3) == 0) raw[51:0] = ($urandom_range(0, 1)) ? '0 : '1;
    return raw;
  endfunction

  // Directed corner values, each applied under two request codes: i mod 8 and 7 - (i mod 8).
  logic [63:0] corners[$] = '{
    64'h0000_0000_4f00_0000,  // f32 2^31
    64'h0000_0000_cf00_0000,  // f32 -2^31
    64'h0000_0000_4f80_0000,  // f32 2^32
    64'h0000_0000_5f00_0000,  // f32 2^63
    64'h0000_0000_df00_0000,  // f32 -2^63
    64'h0000_0000_5f80_0000,  // f32 2^64
    64'hffff_ffff_bf7f_ffff,  // f32 just above -1, junk upper half
    64'h0000_0000_8000_0000,  // f32 -0
    64'h0000_0000_7fc0_0000,  // f32 NaN
    64'h0000_0000_ff80_0000,  // f32 -inf
    64'h0000_0000_0000_0001,  // f32 subnormal
    64'h41e0_0000_0000_0000,  // f64 2^31
    64'hc1e0_0000_0000_0000,  // f64 -2^31
    64'h41df_ffff_ffc0_0000,  // f64 2^31 - 1
    64'h41f0_0000_0000_0000,  // f64 2^32
    64'h41ef_ffff_ffe0_0000,  // f64 2^32 - 1
    64'h43e0_0000_0000_0000,  // f64 2^63
    64'hc3e0_0000_0000_0000,  // f64 -2^63
    64'h43f0_0000_0000_0000,  // f64 2^64
    64'h43ef_ffff_ffff_ffff,  // f64 largest below 2^64
    64'hbfef_ffff_ffff_ffff,  // f64 just above -1
    64'h7ff8_0000_0000_0001,  // f64 NaN
    64'hfff0_0000_0000_0000,  // f64 -inf
    64'h8000_0000_0000_0000,  // f64 -0
    64'hffff_ffff_ffff_ffff   // all ones
  };

  // Stimulus: directed corners, then random words with random gaps.
  initial begin
    fti_pkg::req_type_e kind;
    sb = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    drive_done    = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (corners[i]) begin
      kind = fti_pkg::req_type_e'(i % 8);
      send_word(kind, corners[i]);
      send_word(fti_pkg::req_type_e'(7 - (i % 8)), corners[i]);
      if (i % 4 == 0) send_gap();
    end
    for (int n = 0; n < NumRandom; n++) begin
      kind = fti_pkg::req_type_e'($urandom_range(0, 7));
      send_word(kind, pick_raw(kind));
      if (n % 300 > 100) send_gap();
    end
    s_axis_tvalid <= 1'b0;
    drive_done = 1'b1;
  end

  // Sink: random backpressure, with stretches held ready.
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (($time / 4000) % 3 == 0) m_axis_tready <= 1'b1;
      else m_axis_tready <= (pick_gap() == 0);
    end
  end

  // Check every accepted result word.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tuser);
      words_out++;
      if (m_axis_tuser) traps_seen++;
    end
  end

  // Watchdog: cycles with no accepted word on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    timed_out   = 1'b0;
    @(posedge rst_ni);
    while (idle_cycles < StallLimit && !(drive_done && sb.pending() == 0))
      @(posedge clk_i);
    if (idle_cycles >= StallLimit) begin
      timed_out = 1'b1;
    end else begin
      repeat (20) @(posedge clk_i);
    end
    $display("Sent %0d words over all eight request codes; got %0d results, %0d trapped.",
             words_in, words_out, traps_seen);
    if (!timed_out && sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (sb.pending() != 0) $display("%0d results never arrived", sb.pending());
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
